// File: rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the LRU frame replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

  localparam int FRAMES_DEF = 64;
  localparam int FRAME_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_VICTIM = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2
  } op_t;

  // Request from the control block to the order walker.
  typedef struct packed {
    logic               go;      // start a walk over the order memory
    logic               append;  // write frame at the tail slot
    logic               victim;  // walk removes slot zero instead of a match
    logic [FRAME_W-1:0] frame;
  } lfr_cmd_t;

  // Walk completion status.
  typedef struct packed {
    logic               done;
    logic [FRAME_W-1:0] victim;
  } lfr_stat_t;

endpackage

`default_nettype wire

// File: rtl/lfr_ram.sv
// ----------------------------------------------------------------------------
// lfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lfr_walk.sv
// ----------------------------------------------------------------------------
// lfr_walk
// Order memory and the walker that removes one entry and closes the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_walk #(
  parameter int FRAMES = lfr_pkg::FRAMES_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire lfr_pkg::lfr_cmd_t                          cmd,
  input  wire logic [$clog2(FRAMES+1)-1:0]                count,
  output      lfr_pkg::lfr_stat_t                         stat
);

  import lfr_pkg::*;

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   rd_cnt;
  logic [CNT_W-1:0]   limit;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_slot;
  logic               hit;
  logic               victim_mode;
  logic [FRAME_W-1:0] key;
  logic [FRAME_W-1:0] victim;
  logic               done;

  logic               issue;
  logic               match;
  logic               finish;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [FRAME_W-1:0] ram_wdata;
  logic [FRAME_W-1:0] ram_rdata;

  assign issue  = (state == S_WALK) && (rd_cnt < limit);
  assign match  = rd_vld && !hit && (victim_mode ? (rd_slot == '0) : (ram_rdata == key));
  assign finish = (state == S_WALK) && !issue && !rd_vld;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = cmd.frame;
    if (state == S_IDLE && cmd.append) begin
      ram_we = 1'b1;
    end else if (rd_vld && hit) begin
      // shift the younger entry down over the removed one
      ram_we    = 1'b1;
      ram_waddr = rd_slot - IDX_W'(1);
      ram_wdata = ram_rdata;
    end
  end

  lfr_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(FRAMES)
  ) u_order (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(rd_cnt[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.go) begin
            state       <= S_WALK;
            rd_cnt      <= '0;
            limit       <= count;
            hit         <= 1'b0;
            victim_mode <= cmd.victim;
            key         <= cmd.frame;
          end
        end
        S_WALK: begin
          rd_vld  <= issue;
          rd_slot <= rd_cnt[IDX_W-1:0];
          if (issue) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (match) begin
            hit    <= 1'b1;
            victim <= ram_rdata;
          end
          if (finish) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.done   = done;
  assign stat.victim = victim;

endmodule

`default_nettype wire

// File: rtl/lru_frame_replacer_unit.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer_unit
// Recency-ordered set of evictable frames with unpin, pin and victim events.
// ----------------------------------------------------------------------------
// Unpin, ignored events and a victim request on an empty set give their result
// in the cycle after the transfer, with busy staying low.
// Pin of a present frame and a victim request walk the order memory, one slot
// read per cycle through a single read port; busy stays high during the walk,
// and a new transfer can be taken in the cycle that shows the result.
// Results show for one cycle on done; the receiver cannot stall. Reset clears
// presence flags and the count; the order memory is not cleared.
`default_nettype none

module lru_frame_replacer_unit #(
  parameter int FRAMES = lfr_pkg::FRAMES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [lfr_pkg::OP_W-1:0]     op,
  input  wire logic [lfr_pkg::FRAME_W-1:0]  frame,
  output      logic                         done,
  output      logic                         victim_found,
  output      logic [lfr_pkg::FRAME_W-1:0]  victim_frame,
  output      logic [lfr_pkg::COUNT_W-1:0]  evictable_count
);

  import lfr_pkg::*;

  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int FLAG_N = (FRAMES < 64) ? FRAMES : 64;
  localparam int FLAG_W = (FLAG_N > 1) ? $clog2(FLAG_N) : 1;

  logic [FLAG_N-1:0] flags;
  logic [CNT_W-1:0]  count;
  logic              walk_victim;

  logic              accept;
  logic              frame_ok;
  logic [FLAG_W-1:0] fidx;
  logic              flag_hit;
  logic              victim_ok;
  logic              pin_ok;
  logic              unpin_ok;
  logic              vic_ok;
  logic [FLAG_W-1:0] vidx;

  lfr_cmd_t  cmd;
  lfr_stat_t stat;

  assign accept   = start && !busy;
  assign frame_ok = {1'b0, frame} < (FRAME_W + 1)'(FLAG_N);
  assign fidx     = frame[FLAG_W-1:0];
  assign flag_hit = frame_ok && flags[fidx];

  always_comb begin
    victim_ok = 1'b0;
    pin_ok    = 1'b0;
    unpin_ok  = 1'b0;
    unique case (op_t'(op))
      OP_VICTIM: victim_ok = (count != '0);
      OP_PIN:    pin_ok    = flag_hit;
      OP_UNPIN:  unpin_ok  = frame_ok && !flag_hit && (count < CNT_W'(FRAMES));
      default: ;
    endcase
  end

  assign cmd.go     = accept && (victim_ok || pin_ok);
  assign cmd.append = accept && unpin_ok;
  assign cmd.victim = victim_ok;
  assign cmd.frame  = frame;

  assign vic_ok = {1'b0, stat.victim} < (FRAME_W + 1)'(FLAG_N);
  assign vidx   = stat.victim[FLAG_W-1:0];

  lfr_walk #(
    .FRAMES(FRAMES)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .count(count),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      flags <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        if (victim_ok || pin_ok) begin
          busy        <= 1'b1;
          walk_victim <= victim_ok;
          if (pin_ok) begin
            flags[fidx] <= 1'b0;
          end
        end else begin
          done         <= 1'b1;
          victim_found <= 1'b0;
          victim_frame <= '0;
          if (unpin_ok) begin
            flags[fidx]     <= 1'b1;
            count           <= count + CNT_W'(1);
            evictable_count <= COUNT_W'(count + CNT_W'(1));
          end else begin
            evictable_count <= COUNT_W'(count);
          end
        end
      end
      if (stat.done) begin
        busy            <= 1'b0;
        done            <= 1'b1;
        victim_found    <= walk_victim;
        victim_frame    <= walk_victim ? stat.victim : '0;
        count           <= count - CNT_W'(1);
        evictable_count <= COUNT_W'(count - CNT_W'(1));
        if (walk_victim && vic_ok) begin
          flags[vidx] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lfr_checker.sv
// ----------------------------------------------------------------------------
// lfr_checker
// Port-level checks on the LRU frame replacer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [lfr_pkg::OP_W-1:0]     op,
  input wire logic [lfr_pkg::FRAME_W-1:0]  frame,
  input wire logic                         done,
  input wire logic                         victim_found,
  input wire logic [lfr_pkg::FRAME_W-1:0]  victim_frame,
  input wire logic [lfr_pkg::COUNT_W-1:0]  evictable_count
);

  // every transfer either starts a walk or answers in the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("transfer neither started a walk nor gave a result");

  // a result never overlaps a walk in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a walk always ends in a result
  a_walk_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("walk ended without a result");

  // a found victim comes only out of a walk
  a_victim_walk: assert property (@(posedge clk) disable iff (rst)
    (done && victim_found) |-> $past(busy))
    else $error("victim reported without a walk");

  // a result without a victim carries frame zero
  a_no_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !victim_found) |-> (victim_frame == '0))
    else $error("victim frame nonzero without a victim");

endmodule

bind lru_frame_replacer_unit lfr_checker u_lfr_checker (.*);

`default_nettype wire
